>>> rtl/gdfs_pkg.sv
`default_nettype none
package gdfs_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_X   = 3'd5;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_RESTART = 2'd1,
      OP_STEP    = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_SEARCHING = 3'd0,
      ST_GOAL      = 3'd1,
      ST_NO_PATH   = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_DONE      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PATH_RD,
      S_POP_CHK,
      S_CL_CHK,
      S_NB_ISSUE,
      S_NB_CHK,
      S_TR_ISSUE,
      S_TR_CHK
   } state_type;

   typedef enum logic [1:0] {
      D_MINUS = 2'd0,
      D_ZERO  = 2'd1,
      D_PLUS  = 2'd2
   } delta_type;

   function automatic delta_type nb_dy(input logic [2:0] k);
      delta_type d;
      unique case (k)
         3'd0, 3'd4: d = D_ZERO;
         3'd1, 3'd2, 3'd3: d = D_MINUS;
         default: d = D_PLUS;
      endcase
      return d;
   endfunction

   function automatic delta_type nb_dx(input logic [2:0] k);
      delta_type d;
      unique case (k)
         3'd0, 3'd1, 3'd7: d = D_PLUS;
         3'd2, 3'd6: d = D_ZERO;
         default: d = D_MINUS;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

>>> rtl/gdfs_req_if.sv
`default_nettype none
interface gdfs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [4:0] cell_y;
   logic [4:0] cell_x;
   logic       obstacle;
   logic [9:0] path_index;

   modport source (output valid, op, cell_y, cell_x, obstacle, path_index, input ready);
   modport sink (input valid, op, cell_y, cell_x, obstacle, path_index, output ready);
endinterface
`default_nettype wire

>>> rtl/gdfs_rsp_if.sv
`default_nettype none
interface gdfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [4:0]  path_y;
   logic [4:0]  path_x;
   logic [10:0] path_length;

   modport source (output valid, status, path_y, path_x, path_length, input ready);
   modport sink (input valid, status, path_y, path_x, path_length, output ready);
endinterface
`default_nettype wire

>>> rtl/gdfs_ram.sv
`default_nettype none
module gdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/gdfs_nbr_unit.sv
`default_nettype none
module gdfs_nbr_unit #(
   parameter int YW = 5,
   parameter int XW = 5
) (
   input  logic [YW-1:0] y,
   input  logic [XW-1:0] x,
   input  logic [2:0]    k,
   input  logic [8:0]    rows_eff,
   input  logic [8:0]    cols_eff,
   output logic [YW-1:0] ny,
   output logic [XW-1:0] nx,
   output logic          ok
);
   import gdfs_pkg::*;

   delta_type  dy;
   delta_type  dx;
   logic [8:0] ny_w;
   logic [8:0] nx_w;
   logic       neg;

   always_comb begin
      dy   = nb_dy(k);
      dx   = nb_dx(k);
      neg  = 1'b0;
      ny_w = 9'(y);
      nx_w = 9'(x);
      unique case (dy)
         D_MINUS: begin
            neg  = (y == '0);
            ny_w = 9'(y) - 9'd1;
         end
         D_PLUS: ny_w = 9'(y) + 9'd1;
         default: ny_w = 9'(y);
      endcase
      unique case (dx)
         D_MINUS: begin
            neg  = neg | (x == '0);
            nx_w = 9'(x) - 9'd1;
         end
         D_PLUS: nx_w = 9'(x) + 9'd1;
         default: nx_w = 9'(x);
      endcase
      ok = !neg && (ny_w < rows_eff) && (nx_w < cols_eff);
      ny = ny_w[YW-1:0];
      nx = nx_w[XW-1:0];
   end
endmodule
`default_nettype wire

>>> rtl/grid_dfs_path_search.sv
`default_nettype none
// A load, or a step on an empty stack or after the end, answers from idle, as does a read past
// the path end; other reads first read the path RAM. A step pops the stack and reads the closed
// map: a closed cell is answered as searching; else the cell is closed and either each in-range
// neighbour is checked and pushed if open, or at the goal the path is traced back. A restart
// sweeps the closed map, one cell a cycle. One item is in work at a time. Reset is synchronous;
// afterwards the obstacle and closed maps are swept clear, and no item is accepted during the sweep.
module grid_dfs_path_search #(
   parameter int MAX_ROWS    = 32,
   parameter int MAX_COLS    = 32,
   parameter int STACK_DEPTH = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [gdfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gdfs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   gdfs_req_if.sink                         req_chan,
   gdfs_rsp_if.source                       rsp_chan
);
   import gdfs_pkg::*;

   localparam int YW     = $clog2(MAX_ROWS);
   localparam int XW     = $clog2(MAX_COLS);
   localparam int CAW    = YW + XW;
   localparam int NCELLS = MAX_ROWS * MAX_COLS;
   localparam int PCW    = $clog2(NCELLS + 1);
   localparam int SAW    = $clog2(STACK_DEPTH);
   localparam int SCW    = $clog2(STACK_DEPTH + 1);
   localparam int SEW    = 2 * CAW + 1;

   state_type state_ff, state_in;

   logic [5:0] rows_ff, cols_ff;
   logic [4:0] org_y_ff, org_x_ff, dst_y_ff, dst_x_ff;

   logic [SCW-1:0] stack_count_ff, stack_count_in;
   logic [PCW-1:0] path_count_ff, path_count_in;
   logic [2:0]     last_status_ff, last_status_in;
   logic           finished_ff, finished_in;
   logic [CAW-1:0] clr_addr_ff, clr_addr_in;
   logic           clr_obst_ff, clr_obst_in;
   logic           clr_reply_ff, clr_reply_in;
   logic [CAW-1:0] cur_ff, cur_in;
   logic [CAW-1:0] par_ff, par_in;
   logic           has_par_ff, has_par_in;
   logic [2:0]     k_ff, k_in;
   logic           ovf_ff, ovf_in;
   logic [CAW-1:0] nc_ff, nc_in;
   logic [PCW-1:0] n_ff, n_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [4:0]  rsp_py_ff, rsp_py_in;
   logic [4:0]  rsp_px_ff, rsp_px_in;
   logic [10:0] rsp_len_ff, rsp_len_in;

   logic [8:0] rows_eff, cols_eff;

   logic           obs_we, obs_wd, obs_re, obs_rd;
   logic [CAW-1:0] obs_wa, obs_ra;
   logic           cls_we, cls_wd, cls_re, cls_rd;
   logic [CAW-1:0] cls_wa, cls_ra;
   logic           par_we, par_re;
   logic [CAW-1:0] par_wa, par_ra;
   logic [CAW:0]   par_wd, par_rd;
   logic           stk_we, stk_re;
   logic [SAW-1:0] stk_wa, stk_ra;
   logic [SEW-1:0] stk_wd, stk_rd;
   logic           pth_we, pth_re;
   logic [CAW-1:0] pth_wa, pth_ra, pth_wd, pth_rd;

   logic [YW-1:0]  nb_y;
   logic [XW-1:0]  nb_x;
   logic           nb_ok;

   logic           fin;
   logic [2:0]     fin_status;
   logic [4:0]     fin_py, fin_px;
   logic           accept;
   logic           origin_ok;
   logic [CAW-1:0] origin_cell;
   logic [CAW-1:0] pop_cell;

   assign rows_eff = (9'(rows_ff) < 9'(MAX_ROWS)) ? 9'(rows_ff) : 9'(MAX_ROWS);
   assign cols_eff = (9'(cols_ff) < 9'(MAX_COLS)) ? 9'(cols_ff) : 9'(MAX_COLS);
   assign origin_ok = (9'(org_y_ff) < rows_eff) && (9'(org_x_ff) < cols_eff);
   assign origin_cell = {YW'(org_y_ff), XW'(org_x_ff)};
   assign pop_cell = stk_rd[SEW-1 -: CAW];

   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;

   gdfs_nbr_unit #(.YW(YW), .XW(XW)) u_nbr (
      .y(cur_ff[CAW-1 -: YW]), .x(cur_ff[XW-1:0]), .k(k_ff),
      .rows_eff(rows_eff), .cols_eff(cols_eff),
      .ny(nb_y), .nx(nb_x), .ok(nb_ok)
   );

   gdfs_ram #(.WIDTH(1), .DEPTH(2**CAW)) u_obs (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_wa), .wr_data(obs_wd),
      .rd_en(obs_re), .rd_addr(obs_ra), .rd_data(obs_rd)
   );
   gdfs_ram #(.WIDTH(1), .DEPTH(2**CAW)) u_closed (
      .clock(clock), .wr_en(cls_we), .wr_addr(cls_wa), .wr_data(cls_wd),
      .rd_en(cls_re), .rd_addr(cls_ra), .rd_data(cls_rd)
   );
   gdfs_ram #(.WIDTH(CAW+1), .DEPTH(2**CAW)) u_parent (
      .clock(clock), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_en(par_re), .rd_addr(par_ra), .rd_data(par_rd)
   );
   gdfs_ram #(.WIDTH(SEW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
   );
   gdfs_ram #(.WIDTH(CAW), .DEPTH(2**CAW)) u_path (
      .clock(clock), .wr_en(pth_we), .wr_addr(pth_wa), .wr_data(pth_wd),
      .rd_en(pth_re), .rd_addr(pth_ra), .rd_data(pth_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 6'd32;
         cols_ff  <= 6'd32;
         org_y_ff <= '0;
         org_x_ff <= '0;
         dst_y_ff <= '0;
         dst_x_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROWS:     rows_ff  <= csr_write_data;
            CSR_COLS:     cols_ff  <= csr_write_data;
            CSR_ORIGIN_Y: org_y_ff <= csr_write_data[4:0];
            CSR_ORIGIN_X: org_x_ff <= csr_write_data[4:0];
            CSR_DEST_Y:   dst_y_ff <= csr_write_data[4:0];
            CSR_DEST_X:   dst_x_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         stack_count_ff <= '0;
         path_count_ff  <= '0;
         last_status_ff <= ST_SEARCHING;
         finished_ff    <= 1'b0;
         clr_addr_ff    <= '0;
         clr_obst_ff    <= 1'b1;
         clr_reply_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         path_count_ff  <= path_count_in;
         last_status_ff <= last_status_in;
         finished_ff    <= finished_in;
         clr_addr_ff    <= clr_addr_in;
         clr_obst_ff    <= clr_obst_in;
         clr_reply_ff   <= clr_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      par_ff        <= par_in;
      has_par_ff    <= has_par_in;
      k_ff          <= k_in;
      ovf_ff        <= ovf_in;
      nc_ff         <= nc_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_py_ff     <= rsp_py_in;
      rsp_px_ff     <= rsp_px_in;
      rsp_len_ff    <= rsp_len_in;
   end

   always_comb begin
      state_in       = state_ff;
      stack_count_in = stack_count_ff;
      path_count_in  = path_count_ff;
      last_status_in = last_status_ff;
      finished_in    = finished_ff;
      clr_addr_in    = clr_addr_ff;
      clr_obst_in    = clr_obst_ff;
      clr_reply_in   = clr_reply_ff;
      cur_in         = cur_ff;
      par_in         = par_ff;
      has_par_in     = has_par_ff;
      k_in           = k_ff;
      ovf_in         = ovf_ff;
      nc_in          = nc_ff;
      n_in           = n_ff;
      fin            = 1'b0;
      fin_status     = last_status_ff;
      fin_py         = '0;
      fin_px         = '0;

      obs_we = 1'b0; obs_wa = clr_addr_ff; obs_wd = 1'b0; obs_re = 1'b0; obs_ra = nc_ff;
      cls_we = 1'b0; cls_wa = clr_addr_ff; cls_wd = 1'b0; cls_re = 1'b0; cls_ra = nc_ff;
      par_we = 1'b0; par_wa = cur_ff; par_wd = {has_par_ff, par_ff};
      par_re = 1'b0; par_ra = cur_ff;
      stk_we = 1'b0; stk_wa = stack_count_ff[SAW-1:0]; stk_wd = {nc_ff, cur_ff, 1'b1};
      stk_re = 1'b0; stk_ra = SAW'(stack_count_ff - SCW'(1));
      pth_we = 1'b0; pth_wa = CAW'(n_ff); pth_wd = cur_ff;
      pth_re = 1'b0; pth_ra = CAW'(req_chan.path_index);

      unique case (state_ff)
         S_CLEAR: begin
            cls_we = 1'b1;
            obs_we = clr_obst_ff;
            clr_addr_in = clr_addr_ff + CAW'(1);
            if (clr_addr_ff == '1) begin
               clr_obst_in = 1'b0;
               state_in    = S_IDLE;
               if (clr_reply_ff) begin
                  fin = 1'b1;
                  if (origin_ok) begin
                     stk_we         = 1'b1;
                     stk_wd         = {origin_cell, {CAW{1'b0}}, 1'b0};
                     stack_count_in = stack_count_ff + SCW'(1);
                  end
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_chan.op))
                  OP_LOAD: begin
                     fin = 1'b1;
                     if (32'(req_chan.cell_y) < 32'(MAX_ROWS) &&
                         32'(req_chan.cell_x) < 32'(MAX_COLS)) begin
                        obs_we = 1'b1;
                        obs_wa = {YW'(req_chan.cell_y), XW'(req_chan.cell_x)};
                        obs_wd = req_chan.obstacle;
                     end
                  end
                  OP_RESTART: begin
                     stack_count_in = '0;
                     path_count_in  = '0;
                     finished_in    = 1'b0;
                     last_status_in = ST_SEARCHING;
                     clr_addr_in    = '0;
                     clr_obst_in    = 1'b0;
                     clr_reply_in   = 1'b1;
                     state_in       = S_CLEAR;
                  end
                  OP_STEP: begin
                     if (finished_ff) begin
                        fin        = 1'b1;
                        fin_status = ST_DONE;
                     end else if (stack_count_ff == '0) begin
                        fin         = 1'b1;
                        fin_status  = ST_NO_PATH;
                        finished_in = 1'b1;
                     end else begin
                        stk_re         = 1'b1;
                        stack_count_in = stack_count_ff - SCW'(1);
                        state_in       = S_POP_CHK;
                     end
                  end
                  default: begin
                     pth_re   = 1'b1;
                     n_in     = PCW'(req_chan.path_index);
                     state_in = S_PATH_RD;
                     if (32'(req_chan.path_index) >= 32'(path_count_ff)) begin
                        fin      = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
               endcase
            end
         end
         S_PATH_RD: begin
            fin      = 1'b1;
            fin_py   = 5'(pth_rd[CAW-1 -: YW]);
            fin_px   = 5'(pth_rd[XW-1:0]);
            state_in = S_IDLE;
         end
         S_POP_CHK: begin
            cur_in     = pop_cell;
            par_in     = stk_rd[CAW:1];
            has_par_in = stk_rd[0];
            cls_re     = 1'b1;
            cls_ra     = pop_cell;
            state_in   = S_CL_CHK;
         end
         S_CL_CHK: begin
            if (cls_rd) begin
               fin        = 1'b1;
               fin_status = ST_SEARCHING;
               state_in   = S_IDLE;
            end else begin
               cls_we = 1'b1;
               cls_wa = cur_ff;
               cls_wd = 1'b1;
               par_we = 1'b1;
               if (32'(cur_ff[CAW-1 -: YW]) == 32'(dst_y_ff) &&
                   32'(cur_ff[XW-1:0]) == 32'(dst_x_ff)) begin
                  n_in     = '0;
                  nc_in    = cur_ff;
                  state_in = S_TR_ISSUE;
               end else begin
                  k_in     = '0;
                  ovf_in   = 1'b0;
                  state_in = S_NB_ISSUE;
               end
            end
         end
         S_NB_ISSUE: begin
            if (nb_ok) begin
               nc_in    = {nb_y, nb_x};
               cls_re   = 1'b1;
               cls_ra   = {nb_y, nb_x};
               obs_re   = 1'b1;
               obs_ra   = {nb_y, nb_x};
               state_in = S_NB_CHK;
            end else begin
               k_in = k_ff + 3'd1;
               if (k_ff == 3'd7) begin
                  fin        = 1'b1;
                  fin_status = ovf_ff ? ST_OVERFLOW : ST_SEARCHING;
                  state_in   = S_IDLE;
               end
            end
         end
         S_NB_CHK: begin
            if (!cls_rd && !obs_rd) begin
               if (stack_count_ff == SCW'(STACK_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  stk_we         = 1'b1;
                  stack_count_in = stack_count_ff + SCW'(1);
               end
            end
            k_in     = k_ff + 3'd1;
            state_in = S_NB_ISSUE;
            if (k_ff == 3'd7) begin
               fin        = 1'b1;
               fin_status = ovf_in ? ST_OVERFLOW : ST_SEARCHING;
               state_in   = S_IDLE;
            end
         end
         S_TR_ISSUE: begin
            if (n_ff == PCW'(NCELLS)) begin
               fin           = 1'b1;
               fin_status    = ST_GOAL;
               finished_in   = 1'b1;
               path_count_in = n_ff;
               state_in      = S_IDLE;
            end else begin
               par_re   = 1'b1;
               par_ra   = nc_ff;
               state_in = S_TR_CHK;
            end
         end
         S_TR_CHK: begin
            if (par_rd[CAW]) begin
               pth_we   = 1'b1;
               pth_wd   = nc_ff;
               n_in     = n_ff + PCW'(1);
               nc_in    = par_rd[CAW-1:0];
               state_in = S_TR_ISSUE;
            end else begin
               fin           = 1'b1;
               fin_status    = ST_GOAL;
               finished_in   = 1'b1;
               path_count_in = n_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_py_in     = rsp_py_ff;
      rsp_px_in     = rsp_px_ff;
      rsp_len_in    = rsp_len_ff;
      if (fin) begin
         last_status_in = fin_status;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = fin_status;
         rsp_py_in      = fin_py;
         rsp_px_in      = fin_px;
         rsp_len_in     = 11'(path_count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.path_y      = rsp_py_ff;
   assign rsp_chan.path_x      = rsp_px_ff;
   assign rsp_chan.path_length = rsp_len_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_chan.ready)
      else $error("ready raised while an item is in work");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= SCW'(STACK_DEPTH))
      else $error("stack count beyond depth");
   a_nb_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NB_CHK |-> $past(state_ff) == S_NB_ISSUE)
      else $error("neighbour check without issue");
   a_path_bound: assert property (@(posedge clock) disable iff (reset)
      32'(path_count_ff) <= 32'(NCELLS))
      else $error("path count beyond grid size");
endmodule
`default_nettype wire

>>> tb/gdfs_checker.sv
module gdfs_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [gdfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gdfs_pkg::CSR_DATA_W-1:0] csr_write_data,
   gdfs_req_if                             req,
   gdfs_rsp_if                             rsp,
   output int                              fail_count,
   output int                              pending
);
   import gdfs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID = 32;
   localparam int CELLS = GRID * GRID;
   localparam int DEPTH = 8192;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  path_y;
      logic [4:0]  path_x;
      logic [10:0] path_length;
   } answer_type;

   answer_type answers_due[$];

   logic [5:0] rows_cfg, cols_cfg;
   logic [4:0] oy_cfg, ox_cfg, dy_cfg, dx_cfg;
   bit         blocked [CELLS];
   bit         closed [CELLS];
   logic [9:0] came_from [CELLS];
   bit         has_from [CELLS];
   logic [9:0] stk_cell [DEPTH];
   logic [9:0] stk_from [DEPTH];
   bit         stk_has [DEPTH];
   int         stk_top;
   logic [9:0] route [CELLS];
   int         route_len;
   logic [2:0] last_status;
   bit         finished;

   const int step_y [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
   const int step_x [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

   function automatic int rows_eff();
      return (rows_cfg > GRID) ? GRID : int'(rows_cfg);
   endfunction

   function automatic int cols_eff();
      return (cols_cfg > GRID) ? GRID : int'(cols_cfg);
   endfunction

   function automatic bit push_cell(logic [9:0] c, logic [9:0] from, bit has);
      if (stk_top >= DEPTH) return 0;
      stk_cell[stk_top] = c;
      stk_from[stk_top] = from;
      stk_has[stk_top] = has;
      stk_top++;
      return 1;
   endfunction

   function automatic logic [2:0] explore_step();
      logic [9:0] c, cur;
      int         y, x, ny, nx, n;
      bit         spilled;
      spilled = 0;
      if (finished) return ST_DONE;
      if (stk_top == 0) begin
         finished = 1;
         return ST_NO_PATH;
      end
      stk_top--;
      c = stk_cell[stk_top];
      if (closed[c]) return ST_SEARCHING;
      closed[c] = 1;
      came_from[c] = stk_from[stk_top];
      has_from[c] = stk_has[stk_top];
      y = c / GRID;
      x = c % GRID;
      if (y == dy_cfg && x == dx_cfg) begin
         n = 0;
         cur = c;
         while (n < CELLS && has_from[cur]) begin
            route[n] = cur;
            n++;
            cur = came_from[cur];
         end
         route_len = n;
         finished = 1;
         return ST_GOAL;
      end
      for (int k = 0; k < 8; k++) begin
         ny = y + step_y[k];
         nx = x + step_x[k];
         if (ny < 0 || nx < 0 || ny >= rows_eff() || nx >= cols_eff()) continue;
         if (closed[ny * GRID + nx] || blocked[ny * GRID + nx]) continue;
         if (!push_cell(10'(ny * GRID + nx), c, 1)) spilled = 1;
      end
      return spilled ? ST_OVERFLOW : ST_SEARCHING;
   endfunction

   task automatic predict_item();
      answer_type a;
      a = '0;
      case (op_type'(req.op))
         OP_LOAD: blocked[{req.cell_y, req.cell_x}] = req.obstacle;
         OP_RESTART: begin
            for (int i = 0; i < CELLS; i++) closed[i] = 0;
            stk_top = 0;
            route_len = 0;
            finished = 0;
            last_status = ST_SEARCHING;
            if (oy_cfg < rows_eff() && ox_cfg < cols_eff())
               void'(push_cell({oy_cfg, ox_cfg}, '0, 0));
         end
         OP_STEP: last_status = explore_step();
         default: begin
            if (req.path_index < route_len) begin
               a.path_y = route[req.path_index][9:5];
               a.path_x = route[req.path_index][4:0];
            end
         end
      endcase
      a.status = last_status;
      a.path_length = 11'(route_len);
      answers_due = {answers_due, a};
   endtask

   task automatic report(string field, int want, int got);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rows_cfg = 32;
         cols_cfg = 32;
         {oy_cfg, ox_cfg, dy_cfg, dx_cfg} = '0;
         for (int i = 0; i < CELLS; i++) begin
            blocked[i] = 0;
            closed[i] = 0;
            has_from[i] = 0;
         end
         stk_top = 0;
         route_len = 0;
         last_status = ST_SEARCHING;
         finished = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROWS:     rows_cfg = csr_write_data;
               CSR_COLS:     cols_cfg = csr_write_data;
               CSR_ORIGIN_Y: oy_cfg = csr_write_data[4:0];
               CSR_ORIGIN_X: ox_cfg = csr_write_data[4:0];
               CSR_DEST_Y:   dy_cfg = csr_write_data[4:0];
               CSR_DEST_X:   dx_cfg = csr_write_data[4:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) predict_item();
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: result item with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp.status !== want.status) report("status", want.status, rsp.status);
               if (rsp.path_y !== want.path_y) report("path_y", want.path_y, rsp.path_y);
               if (rsp.path_x !== want.path_x) report("path_x", want.path_x, rsp.path_x);
               if (rsp.path_length !== want.path_length)
                  report("path_length", want.path_length, rsp.path_length);
            end
         end
      end
      pending = answers_due.size();
   end
endmodule

>>> tb/testbench.sv
module testbench;
   import gdfs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    fail_count;
   int                    pending;
   int                    burst_left;
   int                    items_sent;
   int                    stall_phase;

   gdfs_req_if req_chan ();
   gdfs_rsp_if rsp_chan ();

   grid_dfs_path_search u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   gdfs_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case (stall_phase[9:8])
         2'd1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
         default: rsp_chan.ready <= 1'b1;
      endcase
   end

   task automatic send(op_type op, int y = 0, int x = 0, int ob = 0, int idx = 0);
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.cell_y <= 5'(y);
      req_chan.cell_x <= 5'(x);
      req_chan.obstacle <= 1'(ob);
      req_chan.path_index <= 10'(idx);
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(int rows, int cols, int oy, int ox, int dy, int dx);
      int vals [6];
      vals = '{rows, cols, oy, ox, dy, dx};
      settle();
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_write_data <= CSR_DATA_W'(vals[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic search_phase(int rows, int cols, int oy, int ox, int dy, int dx,
                               int steps);
      int span_y, span_x, loads;
      configure(rows, cols, oy, ox, dy, dx);
      span_y = (rows < 1) ? 0 : ((rows > 32) ? 31 : rows - 1);
      span_x = (cols < 1) ? 0 : ((cols > 32) ? 31 : cols - 1);
      loads = $urandom_range(0, 6);
      for (int i = 0; i < loads; i++) begin
         if ($urandom_range(0, 5) == 0)
            send(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
         else
            send(OP_LOAD, $urandom_range(0, span_y), $urandom_range(0, span_x),
                 ($urandom_range(0, 3) == 0));
      end
      send(OP_RESTART);
      for (int i = 0; i < steps; i++) begin
         case ($urandom_range(0, 19))
            0: send(OP_READ, 0, 0, 0, $urandom_range(0, 1023));
            1: send(OP_LOAD, $urandom_range(0, span_y), $urandom_range(0, span_x),
                    $urandom_range(0, 1));
            2: if ($urandom_range(0, 3) == 0) send(OP_RESTART);
               else send(OP_STEP);
            default: send(OP_STEP);
         endcase
      end
      repeat ($urandom_range(2, 6)) send(OP_READ, 0, 0, 0, $urandom_range(0, 12));
      send(OP_READ, 0, 0, 0, $urandom_range(0, 1023));
   endtask

   initial begin
      int r, c;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.op = OP_LOAD;
      req_chan.cell_y = '0;
      req_chan.cell_x = '0;
      req_chan.obstacle = 1'b0;
      req_chan.path_index = '0;
      rsp_chan.ready = 1'b0;
      stall_phase = 0;
      burst_left = 8;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A step before any restart finds an empty stack; the next one is after the end.
      send(OP_STEP);
      send(OP_STEP);
      send(OP_READ, 0, 0, 0, 1023);
      send(OP_LOAD, 31, 31, 1);
      send(OP_LOAD, 31, 31, 0);
      send(OP_RESTART);
      send(OP_STEP);
      send(OP_STEP);
      send(OP_READ, 0, 0, 0, 0);

      configure(3, 4, 0, 0, 2, 3);
      send(OP_LOAD, 1, 1, 1);
      send(OP_LOAD, 0, 1, 1);
      send(OP_RESTART);
      repeat (16) send(OP_STEP);
      for (int i = 0; i < 4; i++) send(OP_READ, 0, 0, 0, i);
      send(OP_READ, 0, 0, 0, 1023);
      send(OP_LOAD, 1, 1, 0);
      send(OP_LOAD, 0, 1, 0);

      // Origin on an obstacle is still pushed and closed.
      configure(2, 2, 1, 1, 0, 0);
      send(OP_LOAD, 1, 1, 1);
      send(OP_RESTART);
      repeat (5) send(OP_STEP);
      send(OP_READ, 0, 0, 0, 0);
      send(OP_LOAD, 1, 1, 0);

      search_phase(1, 1, 0, 0, 0, 0, 3);
      search_phase(0, 5, 0, 0, 0, 1, 3);
      search_phase(5, 0, 0, 0, 1, 0, 3);
      search_phase(4, 4, 4, 0, 1, 1, 3);
      search_phase(32, 1, 31, 0, 0, 0, 40);
      search_phase(63, 63, 0, 0, 31, 31, 60);
      search_phase(32, 32, 31, 31, 0, 31, 60);

      // Open full grid with the goal walled off: a long search that piles up the stack.
      configure(32, 32, 16, 16, 0, 0);
      send(OP_LOAD, 0, 0, 1);
      send(OP_RESTART);
      repeat (100) send(OP_STEP);
      send(OP_READ, 0, 0, 0, 0);
      send(OP_LOAD, 0, 0, 0);

      while (items_sent < 500) begin
         if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 63);
            c = $urandom_range(0, 63);
         end else begin
            r = $urandom_range(1, 7);
            c = $urandom_range(1, 7);
         end
         if ($urandom_range(0, 7) == 0)
            search_phase(r, c, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(1, 30));
         else
            search_phase(r, c, $urandom_range(0, (r > 0 && r < 32) ? r - 1 : 31),
                         $urandom_range(0, (c > 0 && c < 32) ? c - 1 : 31),
                         $urandom_range(0, (r > 0 && r < 32) ? r - 1 : 31),
                         $urandom_range(0, (c > 0 && c < 32) ? c - 1 : 31),
                         $urandom_range(r * c / 2 + 2, 3 * r * c + 4) % 120 + 2);
      end

      settle();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
